// File: src/tun_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

  localparam int COORD_W   = 32;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int MAG_W     = PROD_W - 1;
  localparam int LEN_W     = 7;
  localparam int MANT_W    = 31;
  localparam int SQ_W      = 2 * MANT_W;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int NORM_FRAC = 14;
  localparam int QUO_W     = NORM_FRAC + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int NUM_W     = MANT_W + QUO_W + 2;
  localparam int OUT_W     = 16;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [MANT_W-1:0] mant_t;
  typedef logic [QUO_W-1:0]  quo_t;

  typedef struct packed {
    logic [2:0][MANT_W-1:0] mant;
    logic [2:0]             neg;
    logic                   deg;
  } side_t;

endpackage

`default_nettype wire

// File: src/triangle_unit_normal.sv
// channel | signals                                   | direction
// in      | in_valid_i / in_ready_o, base/tip1/tip2   | 9 x 32b Q16.16 coordinates
// out     | out_valid_o / out_ready_i, normal_*       | 3 x 16b Q2.14 normal, degenerate_o
//
// One transaction per cycle while the output is not stalled; the pipeline has 3
// cross-product stages, 4 scaling stages, 32 square-root digit stages, 15
// divider quotient stages and 1 output register.
// Reset clears only the valid bits; data registers are not reset.
// The whole pipeline advances when the output register is empty or taken,
// so in_ready_o follows out_ready_i while the output holds a result.
`timescale 1ns / 1ps
`default_nettype none

module triangle_unit_normal import tun_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [COORD_W-1:0] base_x_i,
  input  wire logic signed [COORD_W-1:0] base_y_i,
  input  wire logic signed [COORD_W-1:0] base_z_i,
  input  wire logic signed [COORD_W-1:0] tip1_x_i,
  input  wire logic signed [COORD_W-1:0] tip1_y_i,
  input  wire logic signed [COORD_W-1:0] tip1_z_i,
  input  wire logic signed [COORD_W-1:0] tip2_x_i,
  input  wire logic signed [COORD_W-1:0] tip2_y_i,
  input  wire logic signed [COORD_W-1:0] tip2_z_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [OUT_W-1:0]       normal_x_o,
  output logic signed [OUT_W-1:0]       normal_y_o,
  output logic signed [OUT_W-1:0]       normal_z_o,
  output logic                          degenerate_o
);

  logic               en;
  logic [COORD_W-1:0] base [3];
  logic [COORD_W-1:0] tip1 [3];
  logic [COORD_W-1:0] tip2 [3];
  logic               x_vld, p_vld, r_vld, d_vld;
  mag_t               x_mag [3];
  logic [2:0]         x_neg;
  logic [SUM_W-1:0]   p_sum;
  side_t              p_side, r_side;
  logic [ROOT_W-1:0]  r_root;
  quo_t               d_quo [3];
  logic [2:0]         d_neg;
  logic               d_deg;
  logic               out_vld_q;
  logic [OUT_W-1:0]   nrm_q [3];
  logic               deg_q;

  assign base = '{base_x_i, base_y_i, base_z_i};
  assign tip1 = '{tip1_x_i, tip1_y_i, tip1_z_i};
  assign tip2 = '{tip2_x_i, tip2_y_i, tip2_z_i};

  assign en         = out_ready_i | ~out_vld_q;
  assign in_ready_o = en;

  tun_cross u_cross (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i & en),
    .base_i(base), .tip1_i(tip1), .tip2_i(tip2),
    .vld_o(x_vld), .mag_o(x_mag), .neg_o(x_neg)
  );

  tun_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .vld_i(x_vld), .mag_i(x_mag), .neg_i(x_neg),
    .vld_o(p_vld), .sum_o(p_sum), .side_o(p_side)
  );

  tun_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(p_vld), .sum_i(p_sum), .side_i(p_side),
    .vld_o(r_vld), .root_o(r_root), .side_o(r_side)
  );

  tun_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(r_vld), .root_i(r_root), .side_i(r_side),
    .vld_o(d_vld), .quo_o(d_quo), .neg_o(d_neg), .deg_o(d_deg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (d_deg) begin
          nrm_q[k] <= '0;
        end else if (d_neg[k]) begin
          nrm_q[k] <= OUT_W'(-{1'b0, d_quo[k]});
        end else begin
          nrm_q[k] <= OUT_W'(d_quo[k]);
        end
      end
      deg_q <= d_deg;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = deg_q;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |->
      normal_x_o >= -16'sd16384 && normal_x_o <= 16'sd16384 &&
      normal_y_o >= -16'sd16384 && normal_y_o <= 16'sd16384 &&
      normal_z_o >= -16'sd16384 && normal_z_o <= 16'sd16384)
    else $error("normal component out of unit range");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire

// File: src/tun_cross.sv
`timescale 1ns / 1ps
`default_nettype none

module tun_cross import tun_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic [COORD_W-1:0] base_i [3],
  input  wire logic [COORD_W-1:0] tip1_i [3],
  input  wire logic [COORD_W-1:0] tip2_i [3],
  output logic                    vld_o,
  output mag_t                    mag_o  [3],
  output logic [2:0]              neg_o
);

  logic [2:0] vld_q;
  logic signed [EDGE_W-1:0] ea_q [3];
  logic signed [EDGE_W-1:0] eb_q [3];
  logic signed [PROD_W-1:0] pa_q [3];
  logic signed [PROD_W-1:0] pb_q [3];
  mag_t                     mag_q [3];
  logic [2:0]               neg_q;
  logic signed [PROD_W-1:0] diff [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = pa_q[k] - pb_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        ea_q[k] <= $signed({tip1_i[k][COORD_W-1], tip1_i[k]})
                 - $signed({base_i[k][COORD_W-1], base_i[k]});
        eb_q[k] <= $signed({tip2_i[k][COORD_W-1], tip2_i[k]})
                 - $signed({base_i[k][COORD_W-1], base_i[k]});
      end
      pa_q[0] <= ea_q[1] * eb_q[2];
      pb_q[0] <= ea_q[2] * eb_q[1];
      pa_q[1] <= ea_q[2] * eb_q[0];
      pb_q[1] <= ea_q[0] * eb_q[2];
      pa_q[2] <= ea_q[0] * eb_q[1];
      pb_q[2] <= ea_q[1] * eb_q[0];
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= diff[k][PROD_W-1];
        mag_q[k] <= diff[k][PROD_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
      end
    end
  end

  assign vld_o = vld_q[2];
  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

`default_nettype wire

// File: src/tun_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module tun_prep import tun_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire mag_t             mag_i [3],
  input  wire logic [2:0]       neg_i,
  output logic                  vld_o,
  output logic [SUM_W-1:0]      sum_o,
  output side_t                 side_o
);

  logic [3:0]        vld_q;
  mag_t              mag_q [3];
  logic [2:0]        neg_q;
  logic [LEN_W-1:0]  len_q;
  side_t             s5_q, s6_q, s7_q;
  logic [SQ_W-1:0]   sq_q [3];
  logic [SUM_W-1:0]  sum_q;
  mag_t              any_bits;
  logic [LEN_W-1:0]  len_d;
  logic [LEN_W-1:0]  shift;

  always_comb begin
    any_bits = mag_i[0] | mag_i[1] | mag_i[2];
    len_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (any_bits[i]) len_d = LEN_W'(i + 1);
    end
    shift = (len_q > LEN_W'(MANT_W)) ? len_q - LEN_W'(MANT_W) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_i;
      neg_q <= neg_i;
      len_q <= len_d;
      for (int k = 0; k < 3; k++) begin
        s5_q.mant[k] <= MANT_W'(mag_q[k] >> shift);
      end
      s5_q.neg <= neg_q;
      s5_q.deg <= (len_q == '0);
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= s5_q.mant[k] * s5_q.mant[k];
      end
      s6_q  <= s5_q;
      sum_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      s7_q  <= s6_q;
    end
  end

  assign vld_o  = vld_q[3];
  assign sum_o  = sum_q;
  assign side_o = s7_q;

endmodule

`default_nettype wire

// File: src/tun_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module tun_isqrt import tun_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [SUM_W-1:0]  sum_i,
  input  wire side_t             side_i,
  output logic                   vld_o,
  output logic [ROOT_W-1:0]      root_o,
  output side_t                  side_o
);

  logic [ROOT_W-1:0] vld_q;
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SUM_W-1:0]  val_q  [ROOT_W];
  side_t             side_q [ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_W-2:0], vld_i};
    end
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  val_in;
    side_t             side_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    logic              take;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = sum_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign val_in  = val_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign trial = {rem_in, val_in[SUM_W-1 -: 2]};
    assign test  = {root_in, 2'b01};
    assign take  = (trial >= test);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= take ? REM_W'(trial - test) : REM_W'(trial);
        root_q[g] <= {root_in[ROOT_W-2:0], take};
        val_q[g]  <= {val_in[SUM_W-3:0], 2'b00};
        side_q[g] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

`default_nettype wire

// File: src/tun_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tun_div import tun_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire side_t             side_i,
  output logic                   vld_o,
  output quo_t                   quo_o [3],
  output logic [2:0]             neg_o,
  output logic                   deg_o
);

  logic [QUO_W-1:0] vld_q;
  logic [NUM_W-1:0] num_q [QUO_W][3];
  quo_t             quo_q [QUO_W][3];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [2:0]       neg_q [QUO_W];
  logic             deg_q [QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], vld_i};
    end
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    localparam int Bit = QUO_W - 1 - g;
    logic [NUM_W-1:0] num_in [3];
    quo_t             quo_in [3];
    logic [DEN_W-1:0] den_in;
    logic [2:0]       neg_in;
    logic             deg_in;
    logic [NUM_W-1:0] dsh;

    if (g == 0) begin : g_first
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign num_in[k] = (NUM_W'(side_i.mant[k]) << QUO_W) + NUM_W'(root_i);
        assign quo_in[k] = '0;
      end
      assign den_in = {root_i, 1'b0};
      assign neg_in = side_i.neg;
      assign deg_in = side_i.deg;
    end else begin : g_next
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign num_in[k] = num_q[g-1][k];
        assign quo_in[k] = quo_q[g-1][k];
      end
      assign den_in = den_q[g-1];
      assign neg_in = neg_q[g-1];
      assign deg_in = deg_q[g-1];
    end

    assign dsh = NUM_W'(den_in) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          if (num_in[k] >= dsh) begin
            num_q[g][k] <= num_in[k] - dsh;
            quo_q[g][k] <= quo_in[k] | (quo_t'(1) << Bit);
          end else begin
            num_q[g][k] <= num_in[k];
            quo_q[g][k] <= quo_in[k];
          end
        end
        den_q[g] <= den_in;
        neg_q[g] <= neg_in;
        deg_q[g] <= deg_in;
      end
    end
  end

  assign vld_o = vld_q[QUO_W-1];
  assign quo_o = quo_q[QUO_W-1];
  assign neg_o = neg_q[QUO_W-1];
  assign deg_o = deg_q[QUO_W-1];

endmodule

`default_nettype wire

// File: tb/sv/triangle_unit_normal_checker.sv
`timescale 1ns / 1ps

module triangle_unit_normal_checker import tun_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire logic signed [COORD_W-1:0] base_x_i,
  input  wire logic signed [COORD_W-1:0] base_y_i,
  input  wire logic signed [COORD_W-1:0] base_z_i,
  input  wire logic signed [COORD_W-1:0] tip1_x_i,
  input  wire logic signed [COORD_W-1:0] tip1_y_i,
  input  wire logic signed [COORD_W-1:0] tip1_z_i,
  input  wire logic signed [COORD_W-1:0] tip2_x_i,
  input  wire logic signed [COORD_W-1:0] tip2_y_i,
  input  wire logic signed [COORD_W-1:0] tip2_z_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire logic signed [OUT_W-1:0]   normal_x_i,
  input  wire logic signed [OUT_W-1:0]   normal_y_i,
  input  wire logic signed [OUT_W-1:0]   normal_z_i,
  input  wire logic                      degenerate_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             normals_o,
  output int                             degenerates_o
);

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    deg;
  } normal_t;

  normal_t expected_normals[$];

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic normal_t unit_normal(logic signed [COORD_W-1:0] p[9]);
    logic signed [EDGE_W-1:0] a[3];
    logic signed [EDGE_W-1:0] e[3];
    logic signed [PROD_W:0] c[3];
    logic [PROD_W:0] mag[3];
    logic [63:0] m[3];
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] q;
    logic [2:0] neg;
    int len;
    int s;
    normal_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = EDGE_W'(p[3+i]) - EDGE_W'(p[i]);
      e[i] = EDGE_W'(p[6+i]) - EDGE_W'(p[i]);
    end
    c[0] = (PROD_W+1)'(a[1]) * (PROD_W+1)'(e[2]) - (PROD_W+1)'(a[2]) * (PROD_W+1)'(e[1]);
    c[1] = (PROD_W+1)'(a[2]) * (PROD_W+1)'(e[0]) - (PROD_W+1)'(a[0]) * (PROD_W+1)'(e[2]);
    c[2] = (PROD_W+1)'(a[0]) * (PROD_W+1)'(e[1]) - (PROD_W+1)'(a[1]) * (PROD_W+1)'(e[0]);
    len = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? -c[i] : c[i];
      for (int k = 0; k <= PROD_W; k++) if (mag[i][k] && k + 1 > len) len = k + 1;
    end
    res = '0;
    if (len == 0) begin
      res.deg = 1'b1;
      return res;
    end
    s = len > MANT_W ? len - MANT_W : 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = 64'(mag[i] >> s);
      sum = sum + m[i] * m[i];
    end
    r = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (NORM_FRAC + 1)) + r) / (r << 1);
      if (q > (64'd1 << NORM_FRAC)) q = 64'd1 << NORM_FRAC;
      if (neg[i]) q = -q;
      if (i == 0) res.nx = q[OUT_W-1:0];
      if (i == 1) res.ny = q[OUT_W-1:0];
      if (i == 2) res.nz = q[OUT_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    normals_o = 0;
    degenerates_o = 0;
  end

  assign pending_o = expected_normals.size();

  always @(posedge clk_i) begin
    logic signed [COORD_W-1:0] pts[9];
    normal_t want;
    if (rst_ni && in_valid_i && in_ready_i) begin
      pts = '{base_x_i, base_y_i, base_z_i, tip1_x_i, tip1_y_i, tip1_z_i,
              tip2_x_i, tip2_y_i, tip2_z_i};
      expected_normals.push_back(unit_normal(pts));
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      normals_o++;
      if (degenerate_i) degenerates_o++;
      if (expected_normals.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_normals.pop_front();
        if (normal_x_i !== want.nx) report_mismatch("normal_x", normal_x_i, want.nx);
        if (normal_y_i !== want.ny) report_mismatch("normal_y", normal_y_i, want.ny);
        if (normal_z_i !== want.nz) report_mismatch("normal_z", normal_z_i, want.nz);
        if (degenerate_i !== want.deg) report_mismatch("degenerate", degenerate_i, want.deg);
      end
    end
  end

endmodule

// File: tb/sv/triangle_unit_normal_test.sv
`timescale 1ns / 1ps

module triangle_unit_normal_test;
  import tun_pkg::*;

  localparam int LATENCY   = 55;
  localparam int MAX_CYCLE = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] pt[9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
  logic degenerate;
  int errors, pending, normals, degenerates;
  int cycles = 0;
  bit stim_done = 1'b0;

  initial for (int i = 0; i < 9; i++) pt[i] = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  triangle_unit_normal i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .base_x_i(pt[0]), .base_y_i(pt[1]), .base_z_i(pt[2]),
    .tip1_x_i(pt[3]), .tip1_y_i(pt[4]), .tip1_z_i(pt[5]),
    .tip2_x_i(pt[6]), .tip2_y_i(pt[7]), .tip2_z_i(pt[8]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .normal_x_o(normal_x), .normal_y_o(normal_y), .normal_z_o(normal_z),
    .degenerate_o(degenerate)
  );

  triangle_unit_normal_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .base_x_i(pt[0]), .base_y_i(pt[1]), .base_z_i(pt[2]),
    .tip1_x_i(pt[3]), .tip1_y_i(pt[4]), .tip1_z_i(pt[5]),
    .tip2_x_i(pt[6]), .tip2_y_i(pt[7]), .tip2_z_i(pt[8]),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .normal_x_i(normal_x), .normal_y_i(normal_y), .normal_z_i(normal_z),
    .degenerate_i(degenerate),
    .errors_o(errors), .pending_o(pending), .normals_o(normals),
    .degenerates_o(degenerates)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] coord_value(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
    endcase
  endfunction

  task automatic send_triangle(logic [31:0] v[9]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) pt[i] <= v[i];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (cycles > 4000 && cycles < 5500) begin
        out_ready <= 1'b1;
      end else begin
        stall = gap_len();
        out_ready <= (stall == 0);
      end
    end
  end

  initial begin
    logic [31:0] v[9];
    int mode;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, zero edges, parallel edges, axes
    for (int i = 0; i < 9; i++) v[i] = 0;
    send_triangle(v);
    for (int i = 0; i < 9; i++) v[i] = (i < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
    send_triangle(v);
    for (int i = 0; i < 9; i++) v[i] = (i < 3) ? 32'h7fff_ffff : 32'h8000_0000;
    send_triangle(v);
    v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_triangle(v);
    v = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    send_triangle(v);
    v = '{0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0};
    send_triangle(v);
    v = '{0, 0, 0, 0, 32'h1_0000, 0, 32'h1_0000, 0, 0};
    send_triangle(v);
    v = '{0, 0, 0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0};
    send_triangle(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(v);
    v = '{5, 6, 7, 5, 6, 7, 9, 2, 1};
    send_triangle(v);
    v = '{5, 6, 7, 9, 2, 1, 5, 6, 7};
    send_triangle(v);
    v = '{0, 0, 0, 2, 4, 6, 3, 6, 9};
    send_triangle(v);
    v = '{0, 0, 0, 32'hffff_fffe, 32'hffff_fffc, 4, 1, 2, 32'hffff_fffe};
    send_triangle(v);
    v = '{0, 0, 0, 1, 1, 0, 1, 0, 0};
    send_triangle(v);
    // random
    for (int n = 0; n < 700; n++) begin
      if (n == 350) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        if (mode < 5) v[i] = coord_value(0);
        else if (mode < 7) v[i] = coord_value(3);
        else v[i] = coord_value($urandom_range(0, 3));
      end
      if (mode == 9) begin
        // tip1 = base + k*(tip2 - base) with k per axis
        for (int i = 0; i < 3; i++) begin
          v[3+i] = v[i] + (v[6+i] - v[i]) * $urandom_range(0, 3);
          if ($urandom_range(0, 3) == 0) v[6+i] = v[i];
        end
      end
      send_triangle(v);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("checked %0d normals, %0d of them degenerate", normals, degenerates);
    $display("mix of extreme, small-integer, random and collinear triangles");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d transactions never came out", pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
